// ===== rtl/core/longest_common_substring_with_text_core_assert.svh =====
// Assertion macros for the longest common substring core.
`ifndef LONGEST_COMMON_SUBSTRING_WITH_TEXT_CORE_ASSERT_SVH
`define LONGEST_COMMON_SUBSTRING_WITH_TEXT_CORE_ASSERT_SVH
`ifndef SYNTHESIS
// Condition that must hold at every clock edge out of reset.
`define LCS_ASSERT_ALWAYS(label, expr, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (expr)) else $error(msg);
// Same-cycle implication.
`define LCS_ASSERT_IMPLY(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) else $error(msg);
`else
`define LCS_ASSERT_ALWAYS(label, expr, msg)
`define LCS_ASSERT_IMPLY(label, ante, cons, msg)
`endif
`endif

// ===== rtl/core/lcs_pkg.sv =====
// Shared types and constants for the longest common substring core.
package lcs_pkg;

   localparam int MAX_LEN_DEFAULT = 64;
   localparam int SYM_W = 8;
   localparam int LEN_W = 7;
   localparam int POS_W = 6;

   // Input transaction payload
   typedef struct packed {
      logic             mode;
      logic [SYM_W-1:0] symbol;
      logic             last;
   } lcs_req_type;

   // Result transaction payload
   typedef struct packed {
      logic [LEN_W-1:0] match_length;
      logic [POS_W-1:0] start_pos;
      logic [SYM_W-1:0] out_symbol;
      logic             truncated;
      logic             last_out;
   } lcs_rsp_type;

   // Token moving one cell per cycle down the chain
   typedef struct packed {
      logic             valid;
      logic             last;
      logic [SYM_W-1:0] sym;
      logic [POS_W-1:0] row;
      logic [LEN_W-1:0] llen;
      logic [LEN_W-1:0] rmax;
   } lcs_tok_type;

   // Write of one second-string character into its cell
   typedef struct packed {
      logic             en;
      logic [LEN_W-1:0] idx;
      logic [SYM_W-1:0] sym;
   } lcs_load_type;

   // Chain status back to the controller
   typedef struct packed {
      logic             done;
      logic [LEN_W-1:0] best_len;
      logic [POS_W-1:0] best_end;
   } lcs_best_type;

   // Controller states
   typedef enum logic [4:0] {
      ST_LOAD    = 5'b00001,
      ST_FEED    = 5'b00010,
      ST_DRAIN   = 5'b00100,
      ST_EMIT_RD = 5'b01000,
      ST_EMIT_WR = 5'b10000
   } lcs_state_type;

endpackage

// ===== rtl/core/lcs_cell.sv =====
// One systolic cell: holds one second-string character and one diagonal length.
module lcs_cell (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     clear,
   input  logic                     active,
   input  logic                     wr_en,
   input  logic [lcs_pkg::SYM_W-1:0] wr_sym,
   input  lcs_pkg::lcs_tok_type     tok_in,
   output lcs_pkg::lcs_tok_type     tok_out
);
   import lcs_pkg::*;

   logic [SYM_W-1:0] b_ff;
   logic [LEN_W-1:0] diag_ff;
   logic [LEN_W-1:0] diag_in;
   lcs_tok_type      tok_ff;
   lcs_tok_type      tok_in_w;
   logic [LEN_W-1:0] v;

   // Match length for this row and column
   always_comb begin
      if (active && tok_in.valid && (tok_in.sym == b_ff)) begin
         v = diag_ff + LEN_W'(1);
      end else begin
         v = '0;
      end
   end

   // Left length of this row becomes the diagonal of the next row
   always_comb begin
      diag_in = diag_ff;
      if (clear) begin
         diag_in = '0;
      end else if (tok_in.valid) begin
         diag_in = tok_in.llen;
      end
   end

   // Token handed to the right neighbor
   always_comb begin
      tok_in_w      = tok_in;
      tok_in_w.llen = v;
      tok_in_w.rmax = (v > tok_in.rmax) ? v : tok_in.rmax;
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         b_ff <= wr_sym;
      end
      diag_ff <= diag_in;
      if (reset) begin
         tok_ff <= '0;
      end else begin
         tok_ff <= tok_in_w;
      end
   end

   assign tok_out = tok_ff;

endmodule

// ===== rtl/core/lcs_chain.sv =====
// Row of match cells and the tracker that keeps the first longest run.
module lcs_chain #(
   parameter int MAX_LEN = lcs_pkg::MAX_LEN_DEFAULT
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     clear,
   input  lcs_pkg::lcs_load_type    load,
   input  logic [lcs_pkg::LEN_W-1:0] second_count,
   input  lcs_pkg::lcs_tok_type     tok_in,
   output lcs_pkg::lcs_best_type    best
);
   import lcs_pkg::*;

   lcs_tok_type      tok [MAX_LEN+1];
   logic [LEN_W-1:0] best_len_ff;
   logic [LEN_W-1:0] best_len_in;
   logic [POS_W-1:0] best_end_ff;
   logic [POS_W-1:0] best_end_in;

   assign tok[0] = tok_in;

   // Cell j holds character j of the second string
   for (genvar j = 0; j < MAX_LEN; j++) begin : g_cell
      lcs_cell u_cell (
         .clock   (clock),
         .reset   (reset),
         .clear   (clear),
         .active  (LEN_W'(j) < second_count),
         .wr_en   (load.en && (load.idx == LEN_W'(j))),
         .wr_sym  (load.sym),
         .tok_in  (tok[j]),
         .tok_out (tok[j+1])
      );
   end

   // Row maximum leaves the chain in row order; strict compare keeps the first
   always_comb begin
      best_len_in = best_len_ff;
      best_end_in = best_end_ff;
      if (clear) begin
         best_len_in = '0;
         best_end_in = '0;
      end else if (tok[MAX_LEN].valid && (tok[MAX_LEN].rmax > best_len_ff)) begin
         best_len_in = tok[MAX_LEN].rmax;
         best_end_in = tok[MAX_LEN].row;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         best_len_ff <= '0;
         best_end_ff <= '0;
      end else begin
         best_len_ff <= best_len_in;
         best_end_ff <= best_end_in;
      end
   end

   assign best.done     = tok[MAX_LEN].valid && tok[MAX_LEN].last;
   assign best.best_len = best_len_ff;
   assign best.best_end = best_end_ff;

endmodule

// ===== rtl/core/longest_common_substring_with_text_core.sv =====
// Longest common substring core: load, systolic compute and result emit.
//
// Takes two strings of up to MAX_LEN bytes, one character per cycle while
// loading, in any interleaving; each string ends at a transaction with last
// set. Further characters of a long string are dropped and flag the result
// as truncated. When both strings are complete the core stops taking input,
// streams the first string through a row of MAX_LEN cells (one per
// second-string character) by way of the registered read of the first-string
// memory, skipping this pass when the first string is empty. It then emits
// the substring one character per result, each read from memory in a read
// state and then registered in a write state, or one result of length zero if
// nothing matches, and goes back to loading as soon as the final result is
// registered. No clearing pass is needed after reset.
module longest_common_substring_with_text_core #(
   parameter int MAX_LEN = lcs_pkg::MAX_LEN_DEFAULT
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_stall,
   input  lcs_pkg::lcs_req_type req_payload,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output lcs_pkg::lcs_rsp_type rsp_payload
);
   import lcs_pkg::*;

`include "longest_common_substring_with_text_core_assert.svh"

   localparam int AW = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1;
   localparam logic [LEN_W-1:0] MAX_CNT = LEN_W'(MAX_LEN);

   lcs_state_type    state_ff, state_in;
   logic [LEN_W-1:0] first_count_ff, first_count_in;
   logic [LEN_W-1:0] second_count_ff, second_count_in;
   logic             first_done_ff, first_done_in;
   logic             second_done_ff, second_done_in;
   logic             overflow_ff, overflow_in;
   logic [LEN_W-1:0] feed_idx_ff, feed_idx_in;
   logic [LEN_W-1:0] emit_k_ff, emit_k_in;
   logic             rd_valid_ff, rd_valid_in;
   logic             rd_last_ff, rd_last_in;
   logic [POS_W-1:0] rd_row_ff, rd_row_in;
   logic [SYM_W-1:0] rdata_ff;
   logic             rsp_valid_ff, rsp_valid_in;
   lcs_rsp_type      rsp_ff, rsp_in;

   logic [SYM_W-1:0] first_mem [MAX_LEN];

   logic             req_acc;
   logic             mem_wr;
   logic             trigger;
   logic             chain_clear;
   logic [POS_W-1:0] start_w;
   logic [POS_W-1:0] emit_addr;
   logic [POS_W-1:0] rd_addr;
   logic             emit_zero;
   logic             emit_last;
   lcs_load_type     load;
   lcs_tok_type      feed_tok;
   lcs_best_type     best;

   assign req_stall = (state_ff != ST_LOAD);
   assign req_acc   = req_valid && !req_stall;

   // Load bookkeeping
   always_comb begin
      first_count_in  = first_count_ff;
      second_count_in = second_count_ff;
      first_done_in   = first_done_ff;
      second_done_in  = second_done_ff;
      overflow_in     = overflow_ff;
      mem_wr          = 1'b0;
      load.en         = 1'b0;
      load.idx        = second_count_ff;
      load.sym        = req_payload.symbol;
      if (req_acc) begin
         if (!req_payload.mode && !first_done_ff) begin
            if (first_count_ff < MAX_CNT) begin
               mem_wr         = 1'b1;
               first_count_in = first_count_ff + LEN_W'(1);
            end else begin
               overflow_in = 1'b1;
            end
            if (req_payload.last) begin
               first_done_in = 1'b1;
            end
         end else if (req_payload.mode && !second_done_ff) begin
            if (second_count_ff < MAX_CNT) begin
               load.en         = 1'b1;
               second_count_in = second_count_ff + LEN_W'(1);
            end else begin
               overflow_in = 1'b1;
            end
            if (req_payload.last) begin
               second_done_in = 1'b1;
            end
         end
      end
      // Final result registered: ready for the next pair
      if ((state_ff == ST_EMIT_WR) && emit_last) begin
         first_count_in  = '0;
         second_count_in = '0;
         first_done_in   = 1'b0;
         second_done_in  = 1'b0;
         overflow_in     = 1'b0;
      end
   end

   assign trigger     = req_acc && first_done_in && second_done_in;
   assign chain_clear = trigger;

   // Emit addressing
   assign start_w   = POS_W'(LEN_W'(best.best_end) + LEN_W'(1) - best.best_len);
   assign emit_addr = start_w + POS_W'(emit_k_ff);
   assign emit_zero = (best.best_len == '0);
   assign emit_last = emit_zero || ((emit_k_ff + LEN_W'(1)) == best.best_len);
   assign rd_addr   = (state_ff == ST_FEED) ? POS_W'(feed_idx_ff) : emit_addr;

   // Sequencer
   always_comb begin
      state_in     = state_ff;
      feed_idx_in  = feed_idx_ff;
      emit_k_in    = emit_k_ff;
      rd_valid_in  = 1'b0;
      rd_last_in   = 1'b0;
      rd_row_in    = POS_W'(feed_idx_ff);
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_in       = rsp_ff;
      case (state_ff)
         ST_LOAD: begin
            if (trigger) begin
               feed_idx_in = '0;
               emit_k_in   = '0;
               state_in    = (first_count_in == '0) ? ST_EMIT_RD : ST_FEED;
            end
         end
         ST_FEED: begin
            rd_valid_in = 1'b1;
            rd_last_in  = (feed_idx_ff + LEN_W'(1)) == first_count_ff;
            feed_idx_in = feed_idx_ff + LEN_W'(1);
            if (rd_last_in) begin
               state_in = ST_DRAIN;
            end
         end
         ST_DRAIN: begin
            if (best.done) begin
               state_in = ST_EMIT_RD;
            end
         end
         ST_EMIT_RD: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               state_in = ST_EMIT_WR;
            end
         end
         ST_EMIT_WR: begin
            rsp_valid_in        = 1'b1;
            rsp_in.match_length = best.best_len;
            rsp_in.start_pos    = emit_zero ? '0 : start_w;
            rsp_in.out_symbol   = emit_zero ? '0 : rdata_ff;
            rsp_in.truncated    = overflow_ff;
            rsp_in.last_out     = emit_last;
            emit_k_in           = emit_k_ff + LEN_W'(1);
            state_in            = emit_last ? ST_LOAD : ST_EMIT_RD;
         end
         default: begin
            state_in = ST_LOAD;
         end
      endcase
   end

   // First-string memory, one write and one registered read port
   always_ff @(posedge clock) begin
      if (mem_wr) begin
         first_mem[first_count_ff[AW-1:0]] <= req_payload.symbol;
      end
      rdata_ff <= first_mem[rd_addr[AW-1:0]];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff        <= ST_LOAD;
         first_count_ff  <= '0;
         second_count_ff <= '0;
         first_done_ff   <= 1'b0;
         second_done_ff  <= 1'b0;
         overflow_ff     <= 1'b0;
         feed_idx_ff     <= '0;
         emit_k_ff       <= '0;
         rd_valid_ff     <= 1'b0;
         rsp_valid_ff    <= 1'b0;
      end else begin
         state_ff        <= state_in;
         first_count_ff  <= first_count_in;
         second_count_ff <= second_count_in;
         first_done_ff   <= first_done_in;
         second_done_ff  <= second_done_in;
         overflow_ff     <= overflow_in;
         feed_idx_ff     <= feed_idx_in;
         emit_k_ff       <= emit_k_in;
         rd_valid_ff     <= rd_valid_in;
         rsp_valid_ff    <= rsp_valid_in;
      end
      rd_last_ff <= rd_last_in;
      rd_row_ff  <= rd_row_in;
      rsp_ff     <= rsp_in;
   end

   // Row token into the chain
   always_comb begin
      feed_tok       = '0;
      feed_tok.valid = rd_valid_ff;
      feed_tok.last  = rd_last_ff;
      feed_tok.sym   = rdata_ff;
      feed_tok.row   = rd_row_ff;
   end

   lcs_chain #(
      .MAX_LEN (MAX_LEN)
   ) u_chain (
      .clock        (clock),
      .reset        (reset),
      .clear        (chain_clear),
      .load         (load),
      .second_count (second_count_ff),
      .tok_in       (feed_tok),
      .best         (best)
   );

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

   // Checks
   `LCS_ASSERT_ALWAYS(a_count_bound, (first_count_ff <= MAX_CNT) && (second_count_ff <= MAX_CNT), "string count past maximum")
   `LCS_ASSERT_IMPLY(a_out_free, state_ff == ST_EMIT_WR, !rsp_valid_ff, "result register overwritten")
   `LCS_ASSERT_IMPLY(a_emit_addr, (state_ff == ST_EMIT_RD) && (best.best_len != '0), LEN_W'(emit_addr) < first_count_ff, "emit reads past first string")
   `LCS_ASSERT_IMPLY(a_zero_last, rsp_valid_ff && (rsp_ff.match_length == '0), rsp_ff.last_out, "empty result not marked last")

endmodule

// ===== bench/longest_common_substring_with_text_core_test.sv =====
// Self-checking testbench for the longest common substring core.
module longest_common_substring_with_text_core_test;
   import lcs_pkg::*;

   localparam int LEN_MAX = MAX_LEN_DEFAULT;
   localparam logic MODE_FIRST = 1'b0;
   localparam logic MODE_SECOND = 1'b1;
   localparam int RANDOM_ITEMS = 410;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_stall;
   lcs_req_type req_payload = '0;
   logic rsp_valid;
   logic rsp_stall = 1'b0;
   lcs_rsp_type rsp_payload;

   // Stimulus and expectation stores
   lcs_req_type pending_reqs[$];
   lcs_rsp_type expected_chars[$];
   int items_queued = 0;
   int total_items = 0;
   int items_accepted = 0;
   int items_driven = 0;
   int pairs_done = 0;
   int cut_pairs = 0;
   int results_seen = 0;
   int errors = 0;

   // Predictor state: both strings as loaded so far
   logic [7:0] first_chars[LEN_MAX];
   logic [7:0] second_chars[LEN_MAX];
   int first_len = 0;
   int second_len = 0;
   bit first_done = 1'b0;
   bit second_done = 1'b0;
   bit cut_seen = 1'b0;

   longest_common_substring_with_text_core uut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_payload (rsp_payload)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // Load one character; on completing both strings, queue the substring results
   function automatic void predict_substring(lcs_req_type t);
      int best_len;
      int best_row;
      int start;
      int v;
      int prev_row[LEN_MAX];
      int cur_row[LEN_MAX];
      lcs_rsp_type r;
      if (t.mode == MODE_FIRST) begin
         if (first_done) return;
         if (first_len < LEN_MAX) begin
            first_chars[first_len] = t.symbol;
            first_len++;
         end else begin
            cut_seen = 1'b1;
         end
         if (t.last) first_done = 1'b1;
      end else begin
         if (second_done) return;
         if (second_len < LEN_MAX) begin
            second_chars[second_len] = t.symbol;
            second_len++;
         end else begin
            cut_seen = 1'b1;
         end
         if (t.last) second_done = 1'b1;
      end
      if (!(first_done && second_done)) return;

      // Diagonal run lengths, row by row over the first string
      best_len = 0;
      best_row = 0;
      for (int i = 0; i < first_len; i++) begin
         for (int j = 0; j < second_len; j++) begin
            if (first_chars[i] != second_chars[j]) begin
               cur_row[j] = 0;
            end else begin
               v = (i > 0 && j > 0) ? prev_row[j-1] + 1 : 1;
               cur_row[j] = v;
               if (v > best_len) begin
                  best_len = v;
                  best_row = i;
               end
            end
         end
         prev_row = cur_row;
      end

      r.truncated = cut_seen;
      if (best_len == 0) begin
         r.match_length = '0;
         r.start_pos = '0;
         r.out_symbol = '0;
         r.last_out = 1'b1;
         expected_chars.push_back(r);
      end else begin
         start = best_row + 1 - best_len;
         for (int k = 0; k < best_len; k++) begin
            r.match_length = best_len[LEN_W-1:0];
            r.start_pos = start[POS_W-1:0];
            r.out_symbol = first_chars[start + k];
            r.last_out = (k == best_len - 1);
            expected_chars.push_back(r);
         end
      end
      pairs_done++;
      if (cut_seen) cut_pairs++;
      first_len = 0;
      second_len = 0;
      first_done = 1'b0;
      second_done = 1'b0;
      cut_seen = 1'b0;
   endfunction

   // Idle rates: sender light / receiver heavy, then swapped, then none
   function automatic int idle_pct(bit sender);
      if (items_accepted * 3 < total_items) return sender ? 14 : 71;
      if (items_accepted * 3 < total_items * 2) return sender ? 71 : 14;
      return 0;
   endfunction

   task automatic push_item(logic mode, logic [7:0] sym, logic last, bit counted);
      lcs_req_type t;
      t.mode = mode;
      t.symbol = sym;
      t.last = last;
      pending_reqs.push_back(t);
      if (counted) items_queued++;
   endtask

   task automatic fill_random(output logic [7:0] s[$], input int len, input int alpha,
                              input int base);
      s = {};
      repeat (len) s.push_back(8'(base + $urandom_range(alpha - 1)));
   endtask

   // Queue one string pair: 0 = first then second, 1 = second then first, 2 = mixed.
   // With noise, a character for the finished string follows while the other loads.
   task automatic queue_pair(input logic [7:0] s1[$], input logic [7:0] s2[$],
                             input int order, input bit noise);
      int i1;
      int i2;
      bit pick_first;
      bit more1;
      bit more2;
      i1 = 0;
      i2 = 0;
      while (i1 < s1.size() || i2 < s2.size()) begin
         more1 = i1 < s1.size();
         more2 = i2 < s2.size();
         if (!more2) pick_first = 1'b1;
         else if (!more1) pick_first = 1'b0;
         else if (order == 0) pick_first = 1'b1;
         else if (order == 1) pick_first = 1'b0;
         else pick_first = $urandom_range(1);
         if (pick_first) begin
            push_item(MODE_FIRST, s1[i1], i1 == s1.size() - 1, 1'b1);
            i1++;
            if (noise && i1 == s1.size() && i2 < s2.size())
               push_item(MODE_FIRST, 8'($urandom_range(255)), 1'($urandom_range(1)), 1'b0);
         end else begin
            push_item(MODE_SECOND, s2[i2], i2 == s2.size() - 1, 1'b1);
            i2++;
            if (noise && i2 == s2.size() && i1 < s1.size())
               push_item(MODE_SECOND, 8'($urandom_range(255)), 1'($urandom_range(1)), 1'b0);
         end
      end
   endtask

   task automatic compare_field(input string name, input logic [7:0] want,
                                input logic [7:0] got);
      if (got !== want) begin
         $error("%s: expected %0d, got %0d", name, want, got);
         errors++;
      end
   endtask

   // Input side: bookkeeping at the rising edge
   always @(posedge clock) begin
      if (!reset && req_valid && !req_stall) begin
         predict_substring(req_payload);
         items_accepted++;
      end
   end

   // Input side: new transaction or idle at the falling edge
   always @(negedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!req_valid || items_accepted == items_driven) begin
         if (pending_reqs.size() != 0 && $urandom_range(99) >= idle_pct(1'b1)) begin
            req_payload <= pending_reqs.pop_front();
            req_valid <= 1'b1;
            items_driven++;
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // Result side: random stall
   always @(negedge clock) begin
      rsp_stall <= $urandom_range(99) < idle_pct(1'b0);
   end

   // Result side: compare against the oldest expectation
   always @(posedge clock) begin : check_results
      lcs_rsp_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         results_seen++;
         if (expected_chars.size() == 0) begin
            $error("result transaction with nothing expected: length %0d symbol %0d",
                   rsp_payload.match_length, rsp_payload.out_symbol);
            errors++;
         end else begin
            want = expected_chars.pop_front();
            compare_field("match_length", 8'(want.match_length),
                          8'(rsp_payload.match_length));
            compare_field("start_pos", 8'(want.start_pos), 8'(rsp_payload.start_pos));
            compare_field("out_symbol", want.out_symbol, rsp_payload.out_symbol);
            compare_field("truncated", 8'(want.truncated), 8'(rsp_payload.truncated));
            compare_field("last_out", 8'(want.last_out), 8'(rsp_payload.last_out));
         end
      end
   end

   // Reset release
   initial begin
      repeat (12) @(posedge clock);
      @(negedge clock) reset <= 1'b0;
   end

   // Stimulus, drain and verdict
   initial begin : run_stimulus
      logic [7:0] s1[$];
      logic [7:0] s2[$];
      logic [7:0] extra[$];
      int alpha;
      int base;
      int len1;
      int from;
      int span;
      int pick;

      // Directed: byte extremes, both orders, no match, ignored item, ties
      s1 = '{8'h00};
      s2 = '{8'h00};
      queue_pair(s1, s2, 0, 1'b0);
      s1 = '{8'hFF};
      s2 = '{8'hFF};
      queue_pair(s1, s2, 1, 1'b0);
      s1 = '{8'h01, 8'h02};
      s2 = '{8'h03};
      queue_pair(s1, s2, 0, 1'b0);
      s1 = '{8'h05};
      s2 = '{8'h07, 8'h05};
      queue_pair(s1, s2, 0, 1'b1);
      s1 = '{8'h01, 8'h02, 8'h09, 8'h01, 8'h02};
      s2 = '{8'h01, 8'h02};
      queue_pair(s1, s2, 2, 1'b0);
      s1 = '{8'hAA, 8'h55, 8'hAA};
      s2 = '{8'h55, 8'hAA};
      queue_pair(s1, s2, 2, 1'b0);
      s1 = '{8'h80, 8'h7F};
      s2 = '{8'h7F, 8'h80};
      queue_pair(s1, s2, 1, 1'b0);

      // Full-length match, a lone match at the last stored position of a cut string, and a cut second string
      fill_random(s1, LEN_MAX, 256, 0);
      s2 = s1;
      queue_pair(s1, s2, 2, 1'b0);
      fill_random(s1, LEN_MAX + 2, 128, 0);
      s1[LEN_MAX-1] = 8'hC8;
      s2 = '{8'hC8};
      queue_pair(s1, s2, 0, 1'b0);
      fill_random(s1, 5, 4, 8'h30);
      fill_random(s2, LEN_MAX + 6, 4, 8'h30);
      queue_pair(s1, s2, 1, 1'b0);

      // Random pairs: mostly short, small alphabets, often with a planted match
      while (items_queued < RANDOM_ITEMS) begin
         pick = $urandom_range(2);
         alpha = (pick == 0) ? 2 : (pick == 1) ? 4 : 256;
         base = $urandom_range(256 - alpha);
         pick = $urandom_range(99);
         len1 = (pick < 85) ? $urandom_range(8, 1) :
                (pick < 95) ? $urandom_range(32, 9) : $urandom_range(LEN_MAX + 6, LEN_MAX - 4);
         fill_random(s1, len1, alpha, base);
         if ($urandom_range(1)) begin
            fill_random(s2, $urandom_range(3), alpha, base);
            from = $urandom_range(len1 - 1);
            span = $urandom_range(len1 - from, 1);
            for (int k = from; k < from + span; k++) s2.push_back(s1[k]);
            fill_random(extra, $urandom_range(3), alpha, base);
            s2 = {s2, extra};
         end else begin
            pick = $urandom_range(99);
            fill_random(s2, (pick < 90) ? $urandom_range(8, 1) : $urandom_range(LEN_MAX + 6, 9),
                        alpha, base);
         end
         queue_pair(s1, s2, $urandom_range(2), $urandom_range(9) == 0);
      end
      total_items = pending_reqs.size();

      // Drain
      while (reset) @(posedge clock);
      while (pending_reqs.size() != 0 || req_valid) @(posedge clock);
      while (expected_chars.size() != 0) @(posedge clock);
      repeat (2 * LEN_MAX + 40) @(posedge clock);

      $display("covered %0d input transactions over %0d string pairs (%0d cut short)",
               items_accepted, pairs_done, cut_pairs);
      $display("checked %0d result transactions field by field", results_seen);
      if (errors == 0) begin
         $display("longest_common_substring_with_text_core_test: done, clean");
      end else begin
         $display("longest_common_substring_with_text_core_test: done, errors");
      end
      $finish;
   end

   // Watchdog
   initial begin
      #600000;
      $display("longest_common_substring_with_text_core_test: done, errors");
      $finish;
   end

endmodule

// ===== sim.f =====
+incdir+rtl/core
rtl/core/lcs_pkg.sv
rtl/core/lcs_cell.sv
rtl/core/lcs_chain.sv
rtl/core/longest_common_substring_with_text_core.sv
bench/longest_common_substring_with_text_core_test.sv
